>>> design/svf_pkg.sv
`default_nettype none
package svf_pkg;

  localparam int DEF_NUM_SECTIONS = 6;
  localparam int DEF_SAMPLE_BITS  = 24;
  localparam int DEF_COEF_BITS    = 32;

  localparam int ST_W = 48;
  localparam logic signed [ST_W-1:0] ST_MAX = {1'b0, {(ST_W-1){1'b1}}};
  localparam logic signed [ST_W-1:0] ST_MIN = {1'b1, {(ST_W-1){1'b0}}};

  localparam logic [1:0] ACT_FILTER = 2'd0;
  localparam logic [1:0] ACT_COEF   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [2:0] SLOT_A0 = 3'd0;
  localparam logic [2:0] SLOT_A1 = 3'd1;
  localparam logic [2:0] SLOT_A2 = 3'd2;
  localparam logic [2:0] SLOT_M0 = 3'd3;
  localparam logic [2:0] SLOT_M1 = 3'd4;
  localparam logic [2:0] SLOT_M2 = 3'd5;

  typedef struct packed {
    logic              wr;
    logic              clr;
    logic [2:0]        band;
    logic [2:0]        slot;
    logic signed [31:0] value;
  } coef_wr_t;

  function automatic logic signed [ST_W-1:0] sat_st(input logic signed [ST_W+2:0] v);
    logic signed [ST_W-1:0] r;
    if (v > (ST_W+3)'(ST_MAX)) begin
      r = ST_MAX;
    end else if (v < (ST_W+3)'(ST_MIN)) begin
      r = ST_MIN;
    end else begin
      r = v[ST_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/svf_cmul.sv
`default_nettype none
module svf_cmul #(
  parameter int COEF_BITS = svf_pkg::DEF_COEF_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic signed [COEF_BITS-1:0]         c,
  input  wire logic signed [svf_pkg::ST_W-1:0]     x,
  output logic                                     done,
  output logic signed [svf_pkg::ST_W-1:0]          res
);

  localparam int SW = svf_pkg::ST_W;
  localparam int HA = (COEF_BITS + 1) / 2;
  localparam int HB = SW / 2;
  localparam int PW = COEF_BITS + SW;
  localparam int CF = COEF_BITS - 8;

  logic [COEF_BITS-1:0] ua_r;
  logic [SW-1:0]        ub_r;
  logic                 neg_r;
  logic [1:0]           cnt_r;
  logic                 run_r;
  logic                 fin_r;
  logic [PW-1:0]        acc_r;
  logic                 done_r;
  logic signed [SW-1:0] res_r;

  logic [HA-1:0]       a_part;
  logic [HB-1:0]       b_part;
  logic [HA+HB-1:0]    pp;
  logic [PW-1:0]       pp_sh;
  logic [PW:0]         rsum;
  logic [PW-CF:0]      mag;
  logic                ovf;
  logic signed [SW-1:0] res_nxt;

  assign a_part = cnt_r[0] ? HA'(ua_r >> HA) : ua_r[HA-1:0];
  assign b_part = cnt_r[1] ? ub_r[SW-1:HB] : ub_r[HB-1:0];
  assign pp     = (HA+HB)'(a_part) * (HA+HB)'(b_part);

  always_comb begin
    case (cnt_r)
      2'd0:    pp_sh = PW'(pp);
      2'd1:    pp_sh = PW'(pp) << HA;
      2'd2:    pp_sh = PW'(pp) << HB;
      2'd3:    pp_sh = PW'(pp) << (HA + HB);
      default: pp_sh = PW'(pp);
    endcase
  end

  assign rsum = (PW+1)'(acc_r) + ((PW+1)'(1) << (CF - 1));
  assign mag  = (PW-CF+1)'(rsum >> CF);
  assign ovf  = |mag[PW-CF:SW-1];

  always_comb begin
    if (ovf) begin
      res_nxt = neg_r ? svf_pkg::ST_MIN : svf_pkg::ST_MAX;
    end else if (neg_r) begin
      res_nxt = -$signed(mag[SW-1:0]);
    end else begin
      res_nxt = $signed(mag[SW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ua_r  <= c[COEF_BITS-1] ? COEF_BITS'(-c) : COEF_BITS'(c);
        ub_r  <= x[SW-1] ? SW'(-x) : SW'(x);
        neg_r <= c[COEF_BITS-1] ^ x[SW-1];
        acc_r <= '0;
        cnt_r <= 2'd0;
        run_r <= 1'b1;
      end else if (run_r) begin
        acc_r <= acc_r + pp_sh;
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        res_r  <= res_nxt;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

>>> design/svf_cell.sv
`default_nettype none
module svf_cell #(
  parameter int IDX         = 0,
  parameter int SAMPLE_BITS = svf_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_BITS   = svf_pkg::DEF_COEF_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire svf_pkg::coef_wr_t             cfg,
  input  wire logic                          start,
  input  wire logic signed [SAMPLE_BITS-1:0] x_in,
  output logic                               done,
  output logic signed [SAMPLE_BITS-1:0]      y_out
);

  localparam int SW = svf_pkg::ST_W;
  localparam int AL = 33 - SAMPLE_BITS;
  localparam int CF = COEF_BITS - 8;
  localparam logic [SW:0] LIM_P = (SW+1)'((64'(1) << (SAMPLE_BITS - 1)) - 64'(1));
  localparam logic [SW:0] LIM_N = (SW+1)'(64'(1) << (SAMPLE_BITS - 1));

  logic signed [COEF_BITS-1:0] coef_r [6];
  logic signed [SW-1:0] s0_r, s1_r, xs_r, v2_r, v0_r, v1_r;
  logic signed [SW+1:0] sum_r;
  logic [2:0]           k_r;
  logic                 iss_r;
  logic                 done_r;
  logic signed [SAMPLE_BITS-1:0] y_r;

  logic signed [SW-1:0]        xs;
  logic signed [COEF_BITS-1:0] mc;
  logic signed [SW-1:0]        mx;
  logic                        m_done;
  logic signed [SW-1:0]        p;
  logic signed [SW-1:0]        y_full;
  logic [SW:0]                 ymag;
  logic [SW:0]                 yrnd;
  logic signed [SAMPLE_BITS-1:0] y_nxt;
  logic signed [71:0]          wext;

  svf_cmul #(.COEF_BITS(COEF_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (iss_r),
    .c     (mc),
    .x     (mx),
    .done  (m_done),
    .res   (p)
  );

  assign xs   = SW'($signed({x_in, {AL{1'b0}}}));
  assign wext = 72'(cfg.value);

  always_comb begin
    case (k_r)
      3'd0:    begin mc = coef_r[0]; mx = s0_r; end
      3'd1:    begin mc = coef_r[1]; mx = v2_r; end
      3'd2:    begin mc = coef_r[1]; mx = s0_r; end
      3'd3:    begin mc = coef_r[2]; mx = v2_r; end
      3'd4:    begin mc = coef_r[3]; mx = xs_r; end
      3'd5:    begin mc = coef_r[4]; mx = v0_r; end
      3'd6:    begin mc = coef_r[5]; mx = v1_r; end
      default: begin mc = coef_r[0]; mx = s0_r; end
    endcase
  end

  assign y_full = svf_pkg::sat_st((SW+3)'(sum_r) + (SW+3)'(p));
  assign ymag   = y_full[SW-1] ? (SW+1)'(0) - (SW+1)'(y_full) : (SW+1)'(y_full);
  assign yrnd   = (ymag + ((SW+1)'(1) << (AL - 1))) >> AL;

  always_comb begin
    if (!y_full[SW-1]) begin
      y_nxt = (yrnd > LIM_P) ? SAMPLE_BITS'(LIM_P) : SAMPLE_BITS'(yrnd);
    end else if (yrnd > LIM_N) begin
      y_nxt = SAMPLE_BITS'(LIM_N);
    end else begin
      y_nxt = SAMPLE_BITS'((SW+1)'(0) - yrnd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        coef_r[i] <= (i == 3) ? COEF_BITS'(64'(1) << CF) : '0;
      end
      s0_r   <= '0;
      s1_r   <= '0;
      k_r    <= 3'd0;
      iss_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      iss_r  <= 1'b0;
      done_r <= 1'b0;
      if (cfg.wr && ({2'b00, cfg.band} == 5'(IDX))) begin
        case (cfg.slot)
          svf_pkg::SLOT_A0: coef_r[0] <= wext[COEF_BITS-1:0];
          svf_pkg::SLOT_A1: coef_r[1] <= wext[COEF_BITS-1:0];
          svf_pkg::SLOT_A2: coef_r[2] <= wext[COEF_BITS-1:0];
          svf_pkg::SLOT_M0: coef_r[3] <= wext[COEF_BITS-1:0];
          svf_pkg::SLOT_M1: coef_r[4] <= wext[COEF_BITS-1:0];
          svf_pkg::SLOT_M2: coef_r[5] <= wext[COEF_BITS-1:0];
          default: ;
        endcase
      end
      if (cfg.clr) begin
        s0_r <= '0;
        s1_r <= '0;
      end
      if (start) begin
        xs_r  <= xs;
        v2_r  <= svf_pkg::sat_st((SW+3)'(xs) - (SW+3)'(s1_r));
        k_r   <= 3'd0;
        iss_r <= 1'b1;
      end else if (m_done) begin
        case (k_r)
          3'd0: sum_r <= (SW+2)'(p);
          3'd1: v0_r  <= svf_pkg::sat_st((SW+3)'(sum_r) + (SW+3)'(p));
          3'd2: sum_r <= (SW+2)'(s1_r) + (SW+2)'(p);
          3'd3: begin
            v1_r <= svf_pkg::sat_st((SW+3)'(sum_r) + (SW+3)'(p));
            s0_r <= svf_pkg::sat_st(((SW+3)'(v0_r) <<< 1) - (SW+3)'(s0_r));
          end
          3'd4: begin
            sum_r <= (SW+2)'(p);
            s1_r  <= svf_pkg::sat_st(((SW+3)'(v1_r) <<< 1) - (SW+3)'(s1_r));
          end
          3'd5: sum_r <= sum_r + (SW+2)'(p);
          default: begin
            y_r    <= y_nxt;
            done_r <= 1'b1;
          end
        endcase
        if (k_r != 3'd6) begin
          k_r   <= k_r + 3'd1;
          iss_r <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign y_out = y_r;

endmodule
`default_nettype wire

>>> design/svf_equalizer_cascade_top.sv
// Channel  Direction  Fields                                             Handshake
// in_      input      action, sample_in, coef_band, coef_slot, coef_value in_valid/in_stall
// out_     output     sample_out                                         out_valid/out_stall
//
// A filter transaction runs 7 coefficient products per section, one after another on the
// section's one 4-step partial-product multiplier, and the sections run one after another.
// Coefficient writes and clears are applied on acceptance; reset loads passthrough coefficients at once.
// in_stall is high while a sample is in the sections or a finished result waits behind the
// output register; results wait in a one-entry holding stage while out_stall is high.
`default_nettype none
module svf_equalizer_cascade_top #(
  parameter int NUM_SECTIONS = svf_pkg::DEF_NUM_SECTIONS,
  parameter int SAMPLE_BITS  = svf_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_BITS    = svf_pkg::DEF_COEF_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_action,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  wire logic [2:0]                    in_coef_band,
  input  wire logic [2:0]                    in_coef_slot,
  input  wire logic signed [31:0]            in_coef_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_out
);

  logic                          busy_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_r;
  logic                          pend_valid_r;
  logic signed [SAMPLE_BITS-1:0] pend_r;

  logic                 accept;
  logic                 go;
  logic                 out_free;
  svf_pkg::coef_wr_t    cfg;
  logic                          done_w [NUM_SECTIONS];
  logic signed [SAMPLE_BITS-1:0] y_w    [NUM_SECTIONS];
  logic                          fin;

  assign in_stall = busy_r | pend_valid_r;
  assign accept   = in_valid & ~in_stall;
  assign go       = accept && (in_action == svf_pkg::ACT_FILTER);
  assign out_free = ~out_valid_r | ~out_stall;
  assign fin      = done_w[NUM_SECTIONS-1];

  assign cfg.wr    = accept && (in_action == svf_pkg::ACT_COEF);
  assign cfg.clr   = accept && (in_action == svf_pkg::ACT_CLEAR);
  assign cfg.band  = in_coef_band;
  assign cfg.slot  = in_coef_slot;
  assign cfg.value = in_coef_value;

  for (genvar i = 0; i < NUM_SECTIONS; i++) begin : g_sec
    svf_cell #(
      .IDX         (i),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cfg   (cfg),
      .start ((i == 0) ? go : done_w[(i == 0) ? 0 : i - 1]),
      .x_in  ((i == 0) ? in_sample_in : y_w[(i == 0) ? 0 : i - 1]),
      .done  (done_w[i]),
      .y_out (y_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (go) begin
        busy_r <= 1'b1;
      end else if (fin) begin
        busy_r <= 1'b0;
      end
      if (out_free) begin
        if (pend_valid_r) begin
          out_r        <= pend_r;
          out_valid_r  <= 1'b1;
          pend_valid_r <= 1'b0;
        end else if (fin) begin
          out_r       <= y_w[NUM_SECTIONS-1];
          out_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else if (fin) begin
        pend_r       <= y_w[NUM_SECTIONS-1];
        pend_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_r;

  a_go_busy: assert property (@(posedge clk) disable iff (!rst_n) go |=> busy_r)
    else $error("sample accepted but sections not busy");
  a_pend_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r)
    else $error("held result without a result on the output");
  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n) fin |-> busy_r)
    else $error("section chain finished with no sample in flight");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !accept)
    else $error("transaction accepted while a sample is in flight");

endmodule
`default_nettype wire

>>> test/svf_equalizer_cascade_checker.sv
`default_nettype none
module svf_equalizer_cascade_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [1:0]         in_action,
  input  wire logic signed [23:0] in_sample_in,
  input  wire logic [2:0]         in_coef_band,
  input  wire logic [2:0]         in_coef_slot,
  input  wire logic signed [31:0] in_coef_value,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [23:0] out_sample_out,
  output int                      fail_count,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEC = 6;
  localparam int CFRAC = 24;
  localparam int ALIGN = 9;

  logic signed [31:0] coefs [NSEC*6];
  logic signed [47:0] integ [NSEC*2];
  logic signed [23:0] expected_samples [$];

  function automatic logic signed [47:0] clip48(input logic signed [63:0] v);
    if (v > 64'(svf_pkg::ST_MAX)) return svf_pkg::ST_MAX;
    if (v < 64'(svf_pkg::ST_MIN)) return svf_pkg::ST_MIN;
    return v[47:0];
  endfunction

  function automatic logic signed [47:0] coef_mul(input logic signed [31:0] c,
                                                  input logic signed [47:0] x);
    logic signed [95:0] p;
    logic [95:0] mag;
    logic neg;
    p = 96'(c) * 96'(x);
    neg = p < 0;
    mag = neg ? 96'(-p) : 96'(p);
    mag = (mag + (96'd1 << (CFRAC - 1))) >> CFRAC;
    if (mag > (96'd1 << 48)) mag = 96'd1 << 48;
    return clip48(neg ? -64'(mag) : 64'(mag));
  endfunction

  function automatic logic signed [23:0] to_sample(input logic signed [47:0] v);
    logic [47:0] mag;
    logic signed [63:0] r;
    mag = v < 0 ? 48'(-v) : 48'(v);
    r = 64'((64'(mag) + (64'd1 << (ALIGN - 1))) >> ALIGN);
    if (v < 0) r = -r;
    if (r > 64'sd8388607) r = 64'sd8388607;
    if (r < -64'sd8388608) r = -64'sd8388608;
    return r[23:0];
  endfunction

  task automatic reset_model();
    for (int i = 0; i < NSEC*6; i++)
      coefs[i] = (i % 6 == svf_pkg::SLOT_M0) ? (32'sd1 <<< CFRAC) : 32'sd0;
    for (int i = 0; i < NSEC*2; i++) integ[i] = '0;
  endtask

  function automatic logic signed [23:0] equalize(input logic signed [23:0] smp);
    logic signed [23:0] x;
    logic signed [47:0] xs, v0, v1, v2, y, s0, s1;
    x = smp;
    for (int k = 0; k < NSEC; k++) begin
      s0 = integ[2*k];
      s1 = integ[2*k+1];
      xs = 48'(x) <<< ALIGN;
      v2 = clip48(64'(xs) - 64'(s1));
      v0 = clip48(64'(coef_mul(coefs[6*k+svf_pkg::SLOT_A0], s0))
                  + 64'(coef_mul(coefs[6*k+svf_pkg::SLOT_A1], v2)));
      v1 = clip48(64'(s1) + 64'(coef_mul(coefs[6*k+svf_pkg::SLOT_A1], s0))
                  + 64'(coef_mul(coefs[6*k+svf_pkg::SLOT_A2], v2)));
      integ[2*k]   = clip48(2 * 64'(v0) - 64'(s0));
      integ[2*k+1] = clip48(2 * 64'(v1) - 64'(s1));
      y = clip48(64'(coef_mul(coefs[6*k+svf_pkg::SLOT_M0], xs))
                 + 64'(coef_mul(coefs[6*k+svf_pkg::SLOT_M1], v0))
                 + 64'(coef_mul(coefs[6*k+svf_pkg::SLOT_M2], v1)));
      x = to_sample(y);
    end
    return x;
  endfunction

  assign pending = expected_samples.size();

  initial begin
    fail_count = 0;
    reset_model();
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        case (in_action)
          svf_pkg::ACT_FILTER: expected_samples.push_back(equalize(in_sample_in));
          svf_pkg::ACT_COEF: begin
            if (in_coef_band < NSEC && in_coef_slot <= svf_pkg::SLOT_M2)
              coefs[6*in_coef_band + in_coef_slot] = in_coef_value;
          end
          svf_pkg::ACT_CLEAR: for (int i = 0; i < NSEC*2; i++) integ[i] = '0;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected sample_out %0d", out_sample_out);
        end else begin
          if (out_sample_out !== expected_samples[0]) begin
            fail_count++;
            if (fail_count <= 10)
              $display("sample_out mismatch: expected %0d actual %0d",
                       expected_samples[0], out_sample_out);
          end
          void'(expected_samples.pop_front());
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> test/tb_svf_equalizer_cascade_top.sv
`default_nettype none
module tb_svf_equalizer_cascade_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] in_action;
  logic signed [23:0] in_sample_in, out_sample_out;
  logic [2:0] in_coef_band, in_coef_slot;
  logic signed [31:0] in_coef_value;
  int fail_count, pending;
  int cycles;
  bit rx_quiet;

  svf_equalizer_cascade_top dut (.*);

  svf_equalizer_cascade_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int wait_left;
    out_stall = 0;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) wait_left = rx_quiet ? 0 : $urandom_range(0, 6);
      out_stall <= (wait_left > 0);
      if (wait_left > 0) wait_left--;
    end
  end

  task automatic send(input logic [1:0] act, input logic signed [23:0] smp,
                      input logic [2:0] band, input logic [2:0] slot,
                      input logic signed [31:0] val, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_action <= act;
    in_sample_in <= smp;
    in_coef_band <= band;
    in_coef_slot <= slot;
    in_coef_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_coef(input logic [2:0] band, input logic [2:0] slot,
                            input logic signed [31:0] val);
    send(svf_pkg::ACT_COEF, 24'($urandom), band, slot, val, 1);
  endtask

  task automatic settle();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic load_section(input int band, input bit wild);
    for (int s = 0; s <= 5; s++) begin
      if (wild) write_coef(3'(band), 3'(s), $urandom);
      else if (s <= 2) write_coef(3'(band), 3'(s), $urandom_range(0, 32'h0080_0000));
      else write_coef(3'(band), 3'(s),
                      $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
    end
  endtask

  initial begin
    bit gaps;
    logic [1:0] act;
    in_valid = 0;
    in_action = svf_pkg::ACT_FILTER;
    in_sample_in = 0;
    in_coef_band = 0;
    in_coef_slot = 0;
    in_coef_value = 0;
    rx_quiet = 0;
    rst_n = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send(svf_pkg::ACT_FILTER, 24'sh7FFFFF, 0, 0, 0, 0);
    send(svf_pkg::ACT_FILTER, -24'sh800000, 0, 0, 0, 1);
    send(svf_pkg::ACT_FILTER, 0, 0, 0, 0, 1);
    send(2'd3, 24'sh123456, 7, 7, 32'hFFFF_FFFF, 1);
    write_coef(0, svf_pkg::SLOT_A0, 32'sh7FFF_FFFF);
    write_coef(0, svf_pkg::SLOT_A1, 32'sh8000_0000);
    write_coef(0, svf_pkg::SLOT_A2, 32'sh7FFF_FFFF);
    write_coef(0, svf_pkg::SLOT_M1, 32'sh7FFF_FFFF);
    write_coef(6, svf_pkg::SLOT_M0, 32'sh0);
    write_coef(7, svf_pkg::SLOT_M0, 32'sh0);
    write_coef(1, 3'd6, 32'sh0);
    write_coef(1, 3'd7, 32'sh0);
    settle();
    send(svf_pkg::ACT_FILTER, 24'sh7FFFFF, 0, 0, 0, 1);
    send(svf_pkg::ACT_FILTER, -24'sh800000, 0, 0, 0, 1);
    send(svf_pkg::ACT_FILTER, 24'sh000001, 0, 0, 0, 1);
    send(svf_pkg::ACT_CLEAR, 0, 0, 0, 0, 1);
    send(svf_pkg::ACT_FILTER, -24'sh000001, 0, 0, 0, 1);
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      for (int b = 0; b < 6; b++) load_section(b, phase == 3 || phase == 6);
      send(svf_pkg::ACT_CLEAR, 0, 0, 0, 0, 1);
      rx_quiet = (phase == 2);
      for (int n = 0; n < 130; n++) begin
        gaps = (phase != 2) && (n % 40 < 30);
        act = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(2, 3)) : svf_pkg::ACT_FILTER;
        if (act == svf_pkg::ACT_FILTER && $urandom_range(0, 9) == 0)
          send(svf_pkg::ACT_FILTER, $urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000,
               0, 0, 0, gaps);
        else
          send(act, 24'($urandom), 3'($urandom), 3'($urandom), $urandom, gaps);
      end
      settle();
    end
    rx_quiet = 0;
    for (int b = 0; b < 6; b++)
      for (int s = 0; s <= 5; s++)
        write_coef(3'(b), 3'(s), (s == svf_pkg::SLOT_M0) ? 32'sh0100_0000 : 32'sh0);
    settle();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
design/svf_pkg.sv
design/svf_cmul.sv
design/svf_cell.sv
design/svf_equalizer_cascade_top.sv
test/svf_equalizer_cascade_checker.sv
test/tb_svf_equalizer_cascade_top.sv
